// ----- rtl/dpq_pkg.sv -----
package dpq_pkg;

  localparam int HeapDepth     = 64;
  localparam int ConsumerDepth = 16;
  localparam int DeadlineBits  = 32;
  localparam int TagBits       = 16;
  localparam int LimitBits     = 7;
  localparam int ConsBits      = 4;
  localparam int StatusBits    = 4;

  // Request codes.
  localparam logic [1:0] REQ_PUT    = 2'd0;
  localparam logic [1:0] REQ_GET    = 2'd1;
  localparam logic [1:0] REQ_SHUT   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Result status codes.
  localparam logic [3:0] ST_QUEUED     = 4'd0;
  localparam logic [3:0] ST_EVICT      = 4'd1;
  localparam logic [3:0] ST_HANDED     = 4'd2;
  localparam logic [3:0] ST_FULL       = 4'd3;
  localparam logic [3:0] ST_PUT_SHUT   = 4'd4;
  localparam logic [3:0] ST_DELIVERED  = 4'd5;
  localparam logic [3:0] ST_PARKED     = 4'd6;
  localparam logic [3:0] ST_RELEASED   = 4'd7;
  localparam logic [3:0] ST_SHUT_ACK   = 4'd8;
  localparam logic [3:0] ST_STACK_FULL = 4'd9;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;    // capture the request fields
    logic put_write;   // write the new call at the last or next slot
    logic pop_root;    // start a pop: read root and last slot
    logic pop_move;    // move last slot into root
    logic park;        // push the consumer on the stack
    logic unpark;      // pop the consumer stack
    logic rd_node;     // register the parent or children of node i
    logic sift_up;     // compare with parent and swap
    logic sift_down;   // compare with children and swap
    logic rel_step;    // emit one release
    logic set_shut;    // set the shutdown flag and clear the stack
    logic emit;        // drive one result
    logic [3:0] status;
    logic emit_call;   // result carries a call
    logic emit_cons;   // result carries the consumer id
    logic last;
  } dpq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] req;
    logic shut;
    logic heap_empty;
    logic stack_empty;
    logic stack_full;
    logic heap_full;
    logic evict_ok;
    logic up_done;
    logic down_done;
    logic rel_last;
  } dpq_stat_t;

endpackage

// ----- rtl/dpq_ctrl.sv -----
module dpq_ctrl
  import dpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  dpq_stat_t stat,
  output dpq_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DECIDE = 10'b0000000010,
    S_UPRD   = 10'b0000000100,
    S_UPCMP  = 10'b0000001000,
    S_POPRD  = 10'b0000010000,
    S_POPMV  = 10'b0000100000,
    S_DNRD   = 10'b0001000000,
    S_DNCMP  = 10'b0010000000,
    S_REL    = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic [3:0] done_status, done_status_next;
  logic done_call, done_call_next, done_cons, done_cons_next;

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done_status <= ST_QUEUED;
      done_call <= 1'b0;
      done_cons <= 1'b0;
    end else begin
      state <= state_next;
      done_status <= done_status_next;
      done_call <= done_call_next;
      done_cons <= done_cons_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next-state and command decode.
  always_comb begin
    state_next = state;
    done_status_next = done_status;
    done_call_next = done_call;
    done_cons_next = done_cons;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch_in = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_IDLE;
        cmd.emit = 1'b1;
        cmd.last = 1'b1;
        unique case (stat.req)
          REQ_PUT: begin
            if (stat.shut) begin
              cmd.status = ST_PUT_SHUT;
            end else if (stat.heap_empty && !stat.stack_empty) begin
              cmd.unpark = 1'b1;
              cmd.status = ST_HANDED;
              cmd.emit_call = 1'b1;
              cmd.emit_cons = 1'b1;
            end else if (!stat.heap_full) begin
              cmd.emit = 1'b0;
              cmd.put_write = 1'b1;
              done_status_next = ST_QUEUED;
              done_call_next = 1'b0;
              done_cons_next = 1'b0;
              state_next = S_UPRD;
            end else if (!stat.evict_ok) begin
              cmd.status = ST_FULL;
            end else begin
              cmd.emit = 1'b0;
              cmd.put_write = 1'b1;
              done_status_next = ST_EVICT;
              done_call_next = 1'b1;
              done_cons_next = 1'b0;
              state_next = S_UPRD;
            end
          end
          REQ_GET: begin
            if (!stat.heap_empty) begin
              cmd.emit = 1'b0;
              cmd.pop_root = 1'b1;
              state_next = S_POPMV;
            end else if (stat.shut) begin
              cmd.status = ST_RELEASED;
              cmd.emit_cons = 1'b1;
            end else if (!stat.stack_full) begin
              cmd.park = 1'b1;
              cmd.status = ST_PARKED;
              cmd.emit_cons = 1'b1;
            end else begin
              cmd.status = ST_STACK_FULL;
              cmd.emit_cons = 1'b1;
            end
          end
          REQ_SHUT: begin
            if (stat.stack_empty) begin
              cmd.set_shut = 1'b1;
              cmd.status = ST_SHUT_ACK;
            end else begin
              cmd.emit = 1'b0;
              state_next = S_REL;
            end
          end
          default: begin
            cmd.emit = 1'b0;
          end
        endcase
      end
      S_UPRD: begin
        cmd.rd_node = 1'b1;
        state_next = S_UPCMP;
      end
      S_UPCMP: begin
        if (stat.up_done) begin
          state_next = S_DONE;
        end else begin
          cmd.sift_up = 1'b1;
          state_next = S_UPRD;
        end
      end
      S_POPRD: begin
        state_next = S_POPMV;
      end
      S_POPMV: begin
        cmd.pop_move = 1'b1;
        done_status_next = ST_DELIVERED;
        done_call_next = 1'b1;
        done_cons_next = 1'b1;
        state_next = S_DNRD;
      end
      S_DNRD: begin
        cmd.rd_node = 1'b1;
        state_next = S_DNCMP;
      end
      S_DNCMP: begin
        if (stat.down_done) begin
          state_next = S_DONE;
        end else begin
          cmd.sift_down = 1'b1;
          state_next = S_DNRD;
        end
      end
      S_REL: begin
        cmd.rel_step = 1'b1;
        cmd.emit = 1'b1;
        cmd.status = ST_RELEASED;
        cmd.emit_cons = 1'b1;
        cmd.last = stat.rel_last;
        if (stat.rel_last) begin
          cmd.set_shut = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DONE: begin
        cmd.emit = 1'b1;
        cmd.last = 1'b1;
        cmd.status = done_status;
        cmd.emit_call = done_call;
        cmd.emit_cons = done_cons;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // A request is only taken when the sequencer is idle.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_DECIDE))
    else $error("start not followed by decode");
  // A sift-up always ends in the result cycle, never straight to idle.
  a_up_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPCMP && stat.up_done) |=> (state == S_DONE))
    else $error("sift-up did not finish with a result");
  // The final result of a request returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> (state == S_IDLE))
    else $error("last result without return to idle");
`endif

endmodule

// ----- rtl/dpq_dp.sv -----
module dpq_dp
  import dpq_pkg::*;
#(
  parameter int HEAP_DEPTH     = HeapDepth,
  parameter int CONSUMER_DEPTH = ConsumerDepth,
  parameter int DEADLINE_BITS  = DeadlineBits,
  parameter int TAG_BITS       = TagBits
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [1:0]               req_type,
  input  logic [DEADLINE_BITS-1:0] deadline,
  input  logic [TAG_BITS-1:0]      call_tag,
  input  logic [ConsBits-1:0]      consumer_id,
  input  logic                     cfg_we,
  input  logic [LimitBits-1:0]     cfg_data,
  input  dpq_cmd_t                 cmd,
  output dpq_stat_t                stat,
  output logic                     result_valid,
  output logic [StatusBits-1:0]    status,
  output logic [TAG_BITS-1:0]      call_tag_res,
  output logic [DEADLINE_BITS-1:0] call_deadline,
  output logic [ConsBits-1:0]      consumer_id_res,
  output logic                     last
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = AW + 1;
  localparam int SW = (CONSUMER_DEPTH > 1) ? $clog2(CONSUMER_DEPTH) : 1;
  localparam int PW = $clog2(CONSUMER_DEPTH + 1);
  localparam int EW = DEADLINE_BITS + TAG_BITS;

  // Heap entries hold {deadline, tag}.
  logic [EW-1:0] heap_mem [HEAP_DEPTH];
  logic [ConsBits-1:0] stack_mem [CONSUMER_DEPTH];

  logic [CW-1:0] heap_count;
  logic [PW-1:0] parked_count;
  logic [PW-1:0] rel_idx;
  logic          shut_down;
  logic [LimitBits-1:0] queue_limit;

  logic [1:0]               r_req;
  logic [DEADLINE_BITS-1:0] r_dl;
  logic [TAG_BITS-1:0]      r_tag;
  logic [ConsBits-1:0]      r_cons;

  logic [CW-1:0] node;
  logic [EW-1:0] e_node, e_a, e_b;
  logic [EW-1:0] rep;
  logic [EW-1:0] e_last;

  // Effective capacity, clamped to 1..HEAP_DEPTH.
  logic [CW-1:0] lim;
  always_comb begin
    if (queue_limit == '0) begin
      lim = CW'(1);
    end else if (32'(queue_limit) > HEAP_DEPTH) begin
      lim = CW'(HEAP_DEPTH);
    end else begin
      lim = CW'(queue_limit);
    end
  end

  // Node neighbors.
  logic [CW-1:0] par_i, lc_i, rc_i;
  assign par_i = (node - CW'(1)) >> 1;
  assign lc_i  = {node[CW-2:0], 1'b1};
  assign rc_i  = lc_i + CW'(1);

  logic [DEADLINE_BITS-1:0] d_node, d_a, d_b;
  assign d_node = e_node[EW-1:TAG_BITS];
  assign d_a    = e_a[EW-1:TAG_BITS];
  assign d_b    = e_b[EW-1:TAG_BITS];

  logic l_ok, r_ok, pick_r, up_done, down_done;
  assign l_ok = (32'(lc_i) < 32'(heap_count)) && (lc_i[CW-1] == 1'b0 || CW > AW + 1);
  assign r_ok = (32'(rc_i) < 32'(heap_count));
  assign pick_r = r_ok && (d_b < d_a);
  assign up_done = (node == '0) || !(d_node < d_a);
  assign down_done = !l_ok || !((pick_r ? d_b : d_a) < d_node);

  logic [CW-1:0] put_slot;
  assign put_slot = stat.heap_full ? heap_count - CW'(1) : heap_count;

  assign stat.req         = r_req;
  assign stat.shut        = shut_down;
  assign stat.heap_empty  = (heap_count == '0);
  assign stat.stack_empty = (parked_count == '0);
  assign stat.stack_full  = (32'(parked_count) >= CONSUMER_DEPTH);
  assign stat.heap_full   = !(heap_count < lim);
  assign stat.evict_ok    = e_last[EW-1:TAG_BITS] > r_dl;
  assign stat.up_done     = up_done;
  assign stat.down_done   = down_done;
  assign stat.rel_last    = (rel_idx + PW'(1) == parked_count);

  // Heap memory: the moving entry and its neighbor are swapped in one step.
  always_ff @(posedge clk) begin
    if (cmd.put_write) begin
      heap_mem[put_slot[AW-1:0]] <= {r_dl, r_tag};
    end else if (cmd.pop_move) begin
      heap_mem[0] <= e_last;
    end else if (cmd.sift_up) begin
      heap_mem[node[AW-1:0]] <= e_a;
      heap_mem[par_i[AW-1:0]] <= e_node;
    end else if (cmd.sift_down) begin
      heap_mem[node[AW-1:0]] <= pick_r ? e_b : e_a;
      if (pick_r) begin
        heap_mem[rc_i[AW-1:0]] <= e_node;
      end else begin
        heap_mem[lc_i[AW-1:0]] <= e_node;
      end
    end
  end

  // Registered reads, at most two addresses per cycle. The moving entry itself
  // is held in e_node, so only its parent or its children are read.
  always_ff @(posedge clk) begin
    if (cmd.pop_root) begin
      e_last <= heap_mem[heap_count[AW-1:0] - AW'(1)];
    end else if (cmd.latch_in) begin
      e_last <= heap_mem[put_slot[AW-1:0]];
    end
    if (cmd.pop_root) begin
      rep <= heap_mem[0];
    end else if (cmd.put_write && stat.heap_full) begin
      rep <= e_last;
    end
    if (cmd.rd_node) begin
      if (r_req == REQ_PUT) begin
        e_a <= heap_mem[par_i[AW-1:0]];
      end else begin
        e_a <= heap_mem[lc_i[AW-1:0]];
        e_b <= heap_mem[rc_i[AW-1:0]];
      end
    end
  end

  // Request capture, node pointer, moving entry and consumer stack.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      r_req <= req_type;
      r_dl <= deadline;
      r_tag <= call_tag;
      r_cons <= consumer_id;
    end
    if (cmd.put_write) begin
      node <= put_slot;
      e_node <= {r_dl, r_tag};
    end else if (cmd.pop_move) begin
      node <= '0;
      e_node <= e_last;
    end else if (cmd.sift_up) begin
      node <= par_i;
    end else if (cmd.sift_down) begin
      node <= pick_r ? rc_i : lc_i;
    end
    if (cmd.park) begin
      stack_mem[parked_count[SW-1:0]] <= r_cons;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_count <= '0;
      parked_count <= '0;
      rel_idx <= '0;
      shut_down <= 1'b0;
      queue_limit <= LimitBits'(64);
    end else begin
      if (cfg_we) begin
        queue_limit <= cfg_data;
      end
      if (cmd.put_write && !stat.heap_full) begin
        heap_count <= heap_count + CW'(1);
      end else if (cmd.pop_move) begin
        heap_count <= heap_count - CW'(1);
      end
      if (cmd.set_shut) begin
        shut_down <= 1'b1;
        parked_count <= '0;
        rel_idx <= '0;
      end else begin
        if (cmd.park) begin
          parked_count <= parked_count + PW'(1);
        end else if (cmd.unpark) begin
          parked_count <= parked_count - PW'(1);
        end
        if (cmd.rel_step) begin
          rel_idx <= rel_idx + PW'(1);
        end
      end
    end
  end

  // Result outputs, combinational from the command.
  logic [ConsBits-1:0] cons_out;
  always_comb begin
    if (cmd.unpark) begin
      cons_out = stack_mem[parked_count[SW-1:0] - SW'(1)];
    end else if (cmd.rel_step) begin
      cons_out = stack_mem[rel_idx[SW-1:0]];
    end else begin
      cons_out = r_cons;
    end
  end

  assign result_valid    = cmd.emit;
  assign status          = cmd.status;
  assign last            = cmd.last;
  assign consumer_id_res = cmd.emit_cons ? cons_out : '0;
  assign call_tag_res    = !cmd.emit_call ? '0 :
                           cmd.unpark ? r_tag : rep[TAG_BITS-1:0];
  assign call_deadline   = !cmd.emit_call ? '0 :
                           cmd.unpark ? r_dl : rep[EW-1:TAG_BITS];

`ifndef NO_ASSERTIONS
  // The heap never holds more than its storage.
  a_count: assert property (@(posedge clk) disable iff (rst)
    32'(heap_count) <= HEAP_DEPTH)
    else $error("heap count overflow");
  // The consumer stack never overflows.
  a_stack: assert property (@(posedge clk) disable iff (rst)
    32'(parked_count) <= CONSUMER_DEPTH)
    else $error("stack overflow");
  // A pop is only issued on a non-empty heap.
  a_pop: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_root |-> heap_count != '0)
    else $error("pop of empty heap");
`endif

endmodule

// ----- rtl/deadline_priority_queue_evict.sv -----
// Earliest-deadline call queue with parked consumers. Pulse start while busy
// is low; every request gives exactly one result strobe (result_valid), except
// a shutdown with parked consumers, which gives one strobe per consumer in
// consecutive cycles, and an unknown request, which gives none. The receiver
// cannot stall, so results must be taken in the strobe cycle. A request that
// needs no sift gives its result straight from the decode step. A put writes
// the new call and sifts it up; a get reads the root and the last slot, moves
// the last entry into the root and sifts it down. Each sift is the read then
// compare-and-swap loop on the heap memory, one level per pass, and ends in
// the result strobe.
module deadline_priority_queue_evict
  import dpq_pkg::*;
#(
  parameter int HEAP_DEPTH     = HeapDepth,
  parameter int CONSUMER_DEPTH = ConsumerDepth,
  parameter int DEADLINE_BITS  = DeadlineBits,
  parameter int TAG_BITS       = TagBits
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               req_type,
  input  logic [DEADLINE_BITS-1:0] deadline,
  input  logic [TAG_BITS-1:0]      call_tag,
  input  logic [ConsBits-1:0]      consumer_id,
  input  logic                     cfg_we,
  input  logic [LimitBits-1:0]     cfg_data,
  output logic                     result_valid,
  output logic [StatusBits-1:0]    status,
  output logic [TAG_BITS-1:0]      call_tag_res,
  output logic [DEADLINE_BITS-1:0] call_deadline,
  output logic [ConsBits-1:0]      consumer_id_res,
  output logic                     last
);

  dpq_cmd_t  cmd;
  dpq_stat_t stat;

  // Request sequencer.
  dpq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  // Heap, consumer stack and result datapath.
  dpq_dp #(
    .HEAP_DEPTH    (HEAP_DEPTH),
    .CONSUMER_DEPTH(CONSUMER_DEPTH),
    .DEADLINE_BITS (DEADLINE_BITS),
    .TAG_BITS      (TAG_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .req_type       (req_type),
    .deadline       (deadline),
    .call_tag       (call_tag),
    .consumer_id    (consumer_id),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .stat           (stat),
    .result_valid   (result_valid),
    .status         (status),
    .call_tag_res   (call_tag_res),
    .call_deadline  (call_deadline),
    .consumer_id_res(consumer_id_res),
    .last           (last)
  );

endmodule
